// ===== design/transpose_search_table_defines.svh =====
// assertion macros for the transpose search table checker
// no dependencies; included by files that assert
`ifndef TRANSPOSE_SEARCH_TABLE_DEFINES_SVH
`define TRANSPOSE_SEARCH_TABLE_DEFINES_SVH

// antecedent in one cycle implies consequent in the next, ignored during reset
`define TST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// state of the ports in the cycle after a reset cycle
`define TST_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ===== design/tst_pkg.sv =====
// shared types and constants of the transpose search table
// no dependencies
package tst_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;
  localparam int LEN_W  = 7;
  localparam int POS_W  = 6;
  localparam int WORD_W = 32;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [POS_W-1:0]         entry_index;
    logic signed [WORD_W-1:0] entry_value;
    logic signed [WORD_W-1:0] search_key;
  } in_beat_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWAP,
    ST_DONE
  } state_t;

endpackage

// ===== design/tst_mem.sv =====
// entry memory: one write port, one read port with registered read data
// depends on tst_pkg
module tst_mem
  import tst_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] entries [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      entries[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= entries[raddr];
  end

endmodule

// ===== design/tst_ctrl.sv =====
// sequencer for the transpose search table: scan, swap write-back, output register
// depends on tst_pkg; drives the ports of tst_mem
module tst_ctrl
  import tst_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [LEN_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_beat_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_beat_t         out_data,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [WORD_W-1:0] mem_wdata,
  output logic [AW-1:0]     mem_raddr,
  input  logic [WORD_W-1:0] mem_rdata
);

  state_t            state, state_next;
  logic [LEN_W-1:0]  table_length;
  logic [LEN_W-1:0]  limit;
  logic [LEN_W-1:0]  lim_in;
  logic [LEN_W-1:0]  idx, idx_next, idx_inc;
  logic [WORD_W-1:0] key;
  logic [WORD_W-1:0] prev_word;
  out_beat_t         res, res_next;
  logic              accept;
  logic              hit;
  logic              load_out;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign idx_inc  = idx + LEN_W'(1);
  assign hit      = (mem_rdata == key);
  // scan never runs past the table
  assign lim_in   = (int'(table_length) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH) : table_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      table_length <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        table_length <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    res       <= res_next;
    prev_word <= mem_rdata;
    if (accept) begin
      key   <= in_data.search_key;
      limit <= lim_in;
    end
    if (load_out) begin
      out_data <= res;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    res_next   = res;
    mem_we     = 1'b0;
    mem_waddr  = AW'(in_data.entry_index);
    mem_wdata  = in_data.entry_value;
    mem_raddr  = '0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.kind == KIND_WRITE) begin
            // out-of-range writes are dropped but still answered
            mem_we     = (int'(in_data.entry_index) < TABLE_DEPTH);
            res_next   = '{found: 1'b0, position: in_data.entry_index};
            state_next = ST_DONE;
          end else begin
            idx_next   = '0;
            res_next   = '{found: 1'b0, position: '0};
            state_next = (lim_in == '0) ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // rdata holds entry idx; fetch idx+1 ahead of the compare
        mem_raddr = AW'(idx_inc);
        if (hit) begin
          res_next.found = 1'b1;
          if (idx == '0) begin
            res_next.position = '0;
            state_next        = ST_DONE;
          end else begin
            // first half of the swap: predecessor moves down
            res_next.position = POS_W'(idx - LEN_W'(1));
            mem_we            = 1'b1;
            mem_waddr         = AW'(idx);
            mem_wdata         = prev_word;
            state_next        = ST_SWAP;
          end
        end else if (idx_inc == limit) begin
          state_next = ST_DONE;
        end else begin
          idx_next = idx_inc;
        end
      end
      ST_SWAP: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(idx - LEN_W'(1));
        mem_wdata  = key;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/transpose_search_table.sv =====
// Transpose search table: a self-organizing table of 32-bit entries. A write beat
// stores one entry; a search beat scans entries 0 to table_length-1 (capped at the
// table depth) and, on the first match at index i > 0, swaps it with entry i-1 and
// reports position i-1 with found set. A search reads one entry per cycle of the entry
// memory (one write port, one read port), plus the swap write-back on such a hit.
// One item is worked at a time; the next is accepted the cycle after the result is
// handed to the output register. Table contents are undefined until written.
// Depends on tst_pkg, tst_ctrl and tst_mem.
module transpose_search_table
  import tst_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [LEN_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  tst_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tst_mem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== design/tst_checker.sv =====
// port-level checks of the transpose search table, bound to the top level
// depends on tst_pkg and transpose_search_table_defines.svh
`include "transpose_search_table_defines.svh"

module tst_checker
  import tst_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  `TST_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result beat dropped while stalled")
  `TST_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_data), "stalled result beat changed")
  // one item in flight: an accepted beat closes the input side
  `TST_ASSERT_NEXT(a_one_item, clk, rst, in_valid && !in_stall, in_stall, "second beat accepted while busy")
  `TST_ASSERT_AFTER_RESET(a_reset, clk, rst, !out_valid && !in_stall, "not idle after reset")

endmodule

bind transpose_search_table tst_checker u_tst_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/sv/transpose_search_table_tb.sv =====
// testbench for transpose_search_table: directed and random write/search beats
// checked against a behavioral predictor of the table and its transpose swaps
// depends on tst_pkg and the transpose_search_table rtl
module transpose_search_table_tb;
  import tst_pkg::*;

  localparam int DEPTH          = DEFAULT_TABLE_DEPTH;
  localparam int IDLE_LIMIT     = 3000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int PHASE_ITEMS    = 75;
  localparam int NUM_PHASES     = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int MAX_GAP        = 40;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  class lookup_scoreboard;
    logic signed [WORD_W-1:0] entries[DEPTH];
    logic [LEN_W-1:0]         length;
    out_beat_t                pending_results[$];
    int mismatches;
    int checked;
    int hits;
    int misses;
    int writes;

    function new();
      length = '0;
      foreach (entries[i]) entries[i] = '0;
      mismatches = 0;
      checked = 0;
      hits = 0;
      misses = 0;
      writes = 0;
    endfunction

    // first match below min(length, DEPTH), swapped one step toward the front
    function out_beat_t predict_lookup(in_beat_t b);
      out_beat_t r;
      int lim;
      logic signed [WORD_W-1:0] t;
      r = '0;
      if (b.kind == KIND_WRITE) begin
        entries[b.entry_index] = b.entry_value;
        r.position = b.entry_index;
        writes++;
      end else begin
        lim = (length > DEPTH) ? DEPTH : int'(length);
        for (int i = 0; i < lim && !r.found; i++) begin
          if (entries[i] == b.search_key) begin
            r.found = 1'b1;
            if (i > 0) begin
              t = entries[i];
              entries[i] = entries[i-1];
              entries[i-1] = t;
              r.position = POS_W'(i - 1);
            end
          end
        end
        if (r.found) hits++;
        else misses++;
      end
      return r;
    endfunction

    function void note_input(in_beat_t b);
      pending_results.push_back(predict_lookup(b));
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: found=%0d position=%0d", got.found, got.position);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.found !== want.found || got.position !== want.position) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d mismatch: expected found=%0d position=%0d, got found=%0d position=%0d",
                   checked, want.found, want.position, got.found, got.position);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [LEN_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_beat_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_beat_t        out_data;

  lookup_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit pressure_on    = 1'b0;
  bit holdoff_done   = 1'b0;
  int holdoff_count  = 0;
  int quiet_cycles   = 0;
  int items_sent     = 0;

  logic signed [WORD_W-1:0] value_pool[8] = '{
    32'sh0, 32'sh1, -32'sh1, 32'sh80000000, 32'sh7fffffff, 32'sh5a5a5a5a, 32'sh7, 32'sha5a5a5a5
  };

  transpose_search_table dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random stall, plus one long hold-off when pressure is switched on
  always @(posedge clk) begin
    if (pressure_on && !holdoff_done && holdoff_count < HOLDOFF_CYCLES) begin
      out_stall <= 1'b1;
      holdoff_count++;
    end else begin
      if (pressure_on) holdoff_done = 1'b1;
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0, 1:    return value_pool[$urandom_range(0, 7)];
      2:       return $urandom;
      default: return sb.entries[$urandom_range(0, DEPTH - 1)];
    endcase
  endfunction

  // half the keys drawn from the searched range so hits and swaps are common
  function automatic logic signed [WORD_W-1:0] pick_key();
    int lim;
    lim = (sb.length > DEPTH) ? DEPTH : int'(sb.length);
    case ($urandom_range(0, 3))
      0, 1:    return (lim > 0) ? sb.entries[$urandom_range(0, lim - 1)]
                                : value_pool[$urandom_range(0, 7)];
      2:       return value_pool[$urandom_range(0, 7)];
      default: return $urandom;
    endcase
  endfunction

  function automatic in_beat_t write_beat(logic [POS_W-1:0] idx, logic signed [WORD_W-1:0] val);
    in_beat_t b;
    b.kind = KIND_WRITE;
    b.entry_index = idx;
    b.entry_value = val;
    b.search_key = $urandom;
    return b;
  endfunction

  function automatic in_beat_t search_beat(logic signed [WORD_W-1:0] key);
    in_beat_t b;
    b.kind = KIND_SEARCH;
    b.entry_index = POS_W'($urandom);
    b.entry_value = $urandom;
    b.search_key = key;
    return b;
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t b;
    b.kind = ($urandom_range(0, 99) < 60) ? KIND_SEARCH : KIND_WRITE;
    b.entry_index = POS_W'($urandom_range(0, DEPTH - 1));
    b.entry_value = pick_value();
    b.search_key = pick_key();
    return b;
  endfunction

  // offers one beat and returns at the edge where it is accepted
  task automatic send_item(input in_beat_t b);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // sender pauses until every result is back, then the length register is written
  task automatic set_table_length(input logic [LEN_W-1:0] len);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.length = len;
  endtask

  task automatic set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 74; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 74; end
      default:       begin send_idle_pct = 10; recv_stall_pct = 10; end
    endcase
  endtask

  initial begin
    logic [LEN_W-1:0] lens[NUM_PHASES];
    lens[0] = 7'd64;
    lens[1] = 7'd127;
    lens[2] = 7'd1;
    lens[3] = LEN_W'($urandom_range(0, 127));
    lens[4] = 7'd2;
    lens[5] = 7'd63;
    lens[6] = 7'd100;
    lens[7] = LEN_W'($urandom_range(0, DEPTH));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty range, extreme values, hit at the front, swaps, misses
    set_idle_mode(IDLE_NONE);
    set_table_length(7'd0);
    send_item(search_beat(32'sh0));
    send_item(write_beat(6'd0, 32'sh80000000));
    send_item(write_beat(6'd1, 32'sh7fffffff));
    send_item(write_beat(6'd2, 32'sh0));
    send_item(write_beat(6'd3, -32'sh1));
    send_item(write_beat(6'd63, 32'sh5));
    set_table_length(7'd4);
    send_item(search_beat(32'sh80000000));
    send_item(search_beat(-32'sh1));
    send_item(search_beat(-32'sh1));
    send_item(search_beat(32'sh7fffffff));
    send_item(search_beat(32'sh3039));
    send_item(search_beat(32'sh5));

    // every entry written before any longer range is searched
    for (int i = 0; i < DEPTH; i++) send_item(write_beat(POS_W'(i), pick_value()));

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_table_length(lens[p]);
      set_idle_mode(idle_mode_t'(p % 4));
      if (p == 0) pressure_on = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) send_item(random_beat());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d beats: %0d writes, %0d search hits, %0d search misses, %0d results checked",
             items_sent, sb.writes, sb.hits, sb.misses, sb.checked);
    $display("table lengths 0 to 127 incl. saturation, idle/stall mixes and one long output hold-off");
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
